// ===== hdl/pkers_pkg.sv =====
// Package for the packed k-mer equal-range search: types, codes and widths.
`default_nettype none

package pkers_pkg;

  // Fixed widths of the payload and of the stores
  localparam int unsigned KEY_W   = 64;  // packed prefix / key
  localparam int unsigned POS_W   = 15;  // read index, bucket start, read_count
  localparam int unsigned BKT_W   = 16;  // bucket number
  localparam int unsigned LEN_W   = 6;   // key length in bases
  localparam int unsigned FIRST_W = 14;  // first_match_res
  localparam int unsigned CMD_W   = 2;

  localparam logic [BKT_W-1:0] LAST_BUCKET = 16'hFFFF;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_READ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_BKT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP    = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BKT_LO,   // read bucket entry of the key
    ST_BKT_HI,   // read next bucket entry
    ST_BKT_END,  // form the bucket range
    ST_LB_RD,    // lower bound: read the midpoint
    ST_LB_CMP,   // lower bound: narrow
    ST_LB_CHK,   // check the lower bound read for a match
    ST_UB_RD,    // upper bound: read the midpoint
    ST_UB_CMP,   // upper bound: narrow
    ST_DONE      // result waits for the output register
  } seq_state_e;

  // Lookup request from the input side
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } lookup_req_t;

  // Finished lookup
  typedef struct packed {
    logic               valid;
    logic [FIRST_W-1:0] first;
    logic [POS_W-1:0]   count;
  } lookup_res_t;

  // Outcome of one masked compare
  typedef struct packed {
    logic lt;  // read sorts before key
    logic eq;  // read equals key
  } cmp_res_t;

endpackage

`default_nettype wire

// ===== hdl/packed_kmer_equal_range_search_core.sv =====
// Top level of the packed k-mer equal-range search: stores, sequencer, output register.
//
//  channel | valid      | stall       | payload
//  --------+------------+-------------+------------------------------------------------
//  in      | in_valid_i | in_stall_o  | command_i address_i load_value_i lookup_key_i
//          |            |             | key_length_i
//  out     | out_valid_o| out_stall_i | first_match_res_o match_count_o
//  cfg     | cfg_we_i   | (none)      | cfg_wdata_i (read_count)
//
// Loads write their store at the transfer and do not make the core busy. A lookup stalls
// the input until the sequencer is idle: it reads the bucket range, then runs a lower-bound
// and, on a match, an upper-bound binary search (about log2 of the bucket size steps each,
// 14 at most); every step is one read of the prefix RAM followed by one compare. An empty
// bucket skips both searches, a miss the upper one. The result sits in an output register,
// so a new item is taken while it waits; a second finished result holds the sequencer until
// it frees up. The stores are not cleared by reset; only control state and read_count are.
`default_nettype none

module packed_kmer_equal_range_search_core
  import pkers_pkg::*;
#(
  parameter int unsigned MAX_READS     = 16384,
  parameter int unsigned MAX_KEY_BASES = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CMD_W-1:0]   command_i,
  input  wire logic [BKT_W-1:0]   address_i,
  input  wire logic [KEY_W-1:0]   load_value_i,
  input  wire logic [KEY_W-1:0]   lookup_key_i,
  input  wire logic [LEN_W-1:0]   key_length_i,
  // Output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [FIRST_W-1:0] first_match_res_o,
  output logic      [POS_W-1:0]   match_count_o,
  // Configuration
  input  wire logic               cfg_we_i,
  input  wire logic [POS_W-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = (MAX_READS > 1) ? $clog2(MAX_READS) : 1;

  logic             busy;
  logic             in_xfer;
  logic [POS_W-1:0] read_count_q;
  logic [POS_W-1:0] limit;

  assign in_stall_o = busy;
  assign in_xfer    = in_valid_i && !busy;

  // read_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_count_q <= '0;
    end else if (cfg_we_i) begin
      read_count_q <= cfg_wdata_i;
    end
  end

  assign limit = ({17'b0, read_count_q} > 32'(MAX_READS)) ? POS_W'(MAX_READS) : read_count_q;

  // Prefix store write: slots past MAX_READS are dropped
  logic                  rd_we;
  logic [AW+BKT_W-1:0]   waddr_ext;
  logic [POS_W-1:0]      rd_raddr;
  logic [AW+POS_W-1:0]   raddr_ext;
  logic [KEY_W-1:0]      rd_rdata;

  assign rd_we     = in_xfer && (command_i == CMD_LOAD_READ) &&
                     ({16'b0, address_i} < 32'(MAX_READS));
  assign waddr_ext = {{AW{1'b0}}, address_i};
  assign raddr_ext = {{AW{1'b0}}, rd_raddr};

  pkers_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_READS)
  ) u_read_ram (
    .clk_i   (clk_i),
    .we_i    (rd_we),
    .waddr_i (waddr_ext[AW-1:0]),
    .wdata_i (load_value_i),
    .raddr_i (raddr_ext[AW-1:0]),
    .rdata_o (rd_rdata)
  );

  // Bucket store
  logic             bkt_we;
  logic [BKT_W-1:0] bkt_raddr;
  logic [POS_W-1:0] bkt_rdata;

  assign bkt_we = in_xfer && (command_i == CMD_LOAD_BKT);

  pkers_ram #(
    .WIDTH (POS_W),
    .DEPTH (1 << BKT_W)
  ) u_bkt_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (address_i),
    .wdata_i (load_value_i[POS_W-1:0]),
    .raddr_i (bkt_raddr),
    .rdata_o (bkt_rdata)
  );

  // Sequencer
  lookup_req_t req;
  lookup_res_t res;
  logic        res_free;

  assign req.start = in_xfer && (command_i == CMD_LOOKUP);
  assign req.key   = lookup_key_i;
  assign req.len   = key_length_i;
  assign res_free  = !out_valid_o || !out_stall_i;

  pkers_seq #(
    .MAX_KEY_BASES (MAX_KEY_BASES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .limit_i    (limit),
    .bkt_addr_o (bkt_raddr),
    .bkt_data_i (bkt_rdata),
    .rd_addr_o  (rd_raddr),
    .rd_data_i  (rd_rdata),
    .res_free_i (res_free),
    .res_o      (res),
    .busy_o     (busy)
  );

  // Output register
  logic out_valid_q;
  logic out_load;

  assign out_load = res.valid && res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      first_match_res_o <= res.first;
      match_count_o     <= res.count;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/pkers_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module pkers_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/pkers_cmp.sv =====
// Shared compare unit: masked unsigned compare of a read prefix with the key.
`default_nettype none

module pkers_cmp
  import pkers_pkg::*;
(
  input  wire logic [KEY_W-1:0] data_i,  // read prefix from memory
  input  wire logic [KEY_W-1:0] key_i,   // key, already masked
  input  wire logic [KEY_W-1:0] mask_i,
  output cmp_res_t              res_o
);

  logic [KEY_W-1:0] data_m;

  assign data_m    = data_i & mask_i;
  assign res_o.eq  = (data_m == key_i);
  assign res_o.lt  = (data_m < key_i);

endmodule

`default_nettype wire

// ===== hdl/pkers_seq.sv =====
// Lookup sequencer: bucket range, then lower- and upper-bound binary searches.
`default_nettype none

module pkers_seq
  import pkers_pkg::*;
#(
  parameter int unsigned MAX_KEY_BASES = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  lookup_req_t           req_i,
  input  wire logic [POS_W-1:0] limit_i,    // read_count saturated to MAX_READS
  output logic      [BKT_W-1:0] bkt_addr_o,
  input  wire logic [POS_W-1:0] bkt_data_i,
  output logic      [POS_W-1:0] rd_addr_o,
  input  wire logic [KEY_W-1:0] rd_data_i,
  input  wire logic             res_free_i, // output register can take a result
  output lookup_res_t           res_o,
  output logic                  busy_o
);

  seq_state_e state_q, state_d;

  logic [KEY_W-1:0]   key_q, mask_q;
  logic [BKT_W-1:0]   code_q;
  logic [POS_W-1:0]   start_q, lo_q, hi_q, lend_q, ls_q, mid_q;
  logic [FIRST_W-1:0] first_q;
  logic [POS_W-1:0]   count_q;

  // Key mask from the saturated length
  logic [LEN_W-1:0] len_sat;
  logic [6:0]       mask_sh;
  logic [KEY_W-1:0] mask_new;

  assign len_sat  = (req_i.len > LEN_W'(MAX_KEY_BASES)) ? LEN_W'(MAX_KEY_BASES) : req_i.len;
  assign mask_sh  = 7'd64 - {len_sat, 1'b0};
  assign mask_new = (len_sat == '0) ? '0 : ({KEY_W{1'b1}} << mask_sh);

  // Bucket end, saturated to the read limit
  logic [POS_W-1:0] end_raw, end_sat;
  logic             last_bkt;

  assign last_bkt = (code_q == LAST_BUCKET);
  assign end_raw  = last_bkt ? limit_i : bkt_data_i;
  assign end_sat  = (end_raw > limit_i) ? limit_i : end_raw;

  // Midpoints
  logic [POS_W:0]   lb_sum, ub_sum;
  logic [POS_W-1:0] lb_mid, ub_mid;

  assign lb_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign lb_mid = lb_sum[POS_W:1];
  assign ub_sum = {1'b0, ls_q} + {1'b0, lend_q};
  assign ub_mid = ub_sum[POS_W:1] + POS_W'(1);

  // Shared compare
  cmp_res_t cmp;

  pkers_cmp u_cmp (
    .data_i (rd_data_i),
    .key_i  (key_q),
    .mask_i (mask_q),
    .res_o  (cmp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) state_d = ST_BKT_LO;
      end
      ST_BKT_LO:  state_d = ST_BKT_HI;
      ST_BKT_HI:  state_d = ST_BKT_END;
      ST_BKT_END: begin
        state_d = (start_q >= end_sat) ? ST_DONE : ST_LB_RD;
      end
      ST_LB_RD: begin
        state_d = (lo_q == hi_q) ? ST_LB_CHK : ST_LB_CMP;
      end
      ST_LB_CMP:  state_d = ST_LB_RD;
      ST_LB_CHK: begin
        state_d = cmp.eq ? ST_UB_RD : ST_DONE;
      end
      ST_UB_RD: begin
        state_d = (ls_q == lend_q) ? ST_DONE : ST_UB_CMP;
      end
      ST_UB_CMP:  state_d = ST_UB_RD;
      ST_DONE: begin
        if (res_free_i) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs: memory addresses and result
  always_comb begin
    bkt_addr_o = code_q;
    rd_addr_o  = lb_mid;
    case (state_q)
      ST_BKT_HI: bkt_addr_o = code_q + BKT_W'(1);
      ST_UB_RD:  rd_addr_o  = ub_mid;
      default: begin
        bkt_addr_o = code_q;
        rd_addr_o  = lb_mid;
      end
    endcase
    res_o.valid = (state_q == ST_DONE);
    res_o.first = first_q;
    res_o.count = count_q;
    busy_o      = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          mask_q  <= mask_new;
          key_q   <= req_i.key & mask_new;
          code_q  <= req_i.key[KEY_W-1 -: BKT_W];
          first_q <= '0;
          count_q <= '0;
        end
      end
      ST_BKT_HI: start_q <= bkt_data_i;
      ST_BKT_END: begin
        lo_q   <= start_q;
        hi_q   <= end_sat - POS_W'(1);
        lend_q <= end_sat - POS_W'(1);
      end
      ST_LB_RD:  mid_q <= lb_mid;
      ST_LB_CMP: begin
        if (cmp.lt) begin
          lo_q <= mid_q + POS_W'(1);
        end else begin
          hi_q <= mid_q;
          if (!cmp.eq) lend_q <= mid_q;
        end
      end
      ST_LB_CHK: ls_q <= lo_q;
      ST_UB_RD: begin
        mid_q <= ub_mid;
        if (ls_q == lend_q) begin
          first_q <= lo_q[FIRST_W-1:0];
          count_q <= lend_q - lo_q + POS_W'(1);
        end
      end
      ST_UB_CMP: begin
        if (cmp.lt || cmp.eq) begin
          ls_q <= mid_q;
        end else begin
          lend_q <= mid_q - POS_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== verif/packed_kmer_equal_range_search_core_test.sv =====
// Self-checking testbench for the packed k-mer equal-range search core.
`timescale 1ns / 1ps

module packed_kmer_equal_range_search_core_test;
  import pkers_pkg::*;

  localparam int unsigned MAX_READS  = 16384;
  localparam int unsigned MAX_BASES  = 32;
  localparam int unsigned SETTLE     = 100;      // quiet time at the end of drain()
  localparam int unsigned ITEMS      = 750;
  localparam int unsigned LIMIT      = 2000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One lookup answer
  typedef struct packed {
    logic [FIRST_W-1:0] first;
    logic [POS_W-1:0]   count;
  } range_t;

  // Mirror of both stores plus the queue of lookup answers still owed by the core
  class equal_range_tracker;
    logic [KEY_W-1:0] prefix_mem [MAX_READS];
    bit               prefix_set [MAX_READS];
    logic [POS_W-1:0] bucket_mem [65536];
    bit               bucket_set [65536];
    int unsigned      read_total;
    range_t           pending_ranges [$];
    int unsigned      errors;
    int unsigned      answered;

    function new();
      read_total = 0;
      errors     = 0;
      answered   = 0;
    endfunction

    function void set_read_count(logic [POS_W-1:0] v);
      read_total = v;
    endfunction

    function int unsigned pending();
      return pending_ranges.size();
    endfunction

    // Bucket [start, stop) after saturation to the table size and read_count
    function void bucket_span(logic [BKT_W-1:0] code, output int unsigned start,
                              output int unsigned stop);
      int unsigned limit;
      limit = (read_total > MAX_READS) ? MAX_READS : read_total;
      start = bucket_mem[code];
      stop  = (code != LAST_BUCKET) ? bucket_mem[code + 1] : limit;
      if (stop > limit) stop = limit;
    endfunction

    // True when a lookup of this key touches only written entries
    function bit lookup_safe(logic [KEY_W-1:0] key);
      logic [BKT_W-1:0] code;
      int unsigned start, stop, i;
      code = key[63:48];
      if (!bucket_set[code]) return 0;
      if (code != LAST_BUCKET && !bucket_set[code + 1]) return 0;
      bucket_span(code, start, stop);
      for (i = start; i < stop; i++)
        if (!prefix_set[i]) return 0;
      return 1;
    endfunction

    // -1: read sorts before key, 0: equal under mask, +1: after
    function int order_of(int unsigned idx, logic [KEY_W-1:0] key, logic [KEY_W-1:0] mask);
      logic [KEY_W-1:0] a, b;
      a = (idx < MAX_READS) ? (prefix_mem[idx] & mask) : '0;
      b = key & mask;
      if (a == b) return 0;
      return (a < b) ? -1 : 1;
    endfunction

    // Lower-bound then upper-bound search over the key's bucket
    function range_t search_range(logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
      int unsigned bases, start, stop, lo, hi, top, ls, mid;
      logic [KEY_W-1:0] mask;
      int c;
      range_t res;
      res   = '0;
      bases = (len > MAX_BASES) ? MAX_BASES : len;
      mask  = (bases == 0) ? '0 : ~64'h0 << (64 - 2 * bases);
      bucket_span(key[63:48], start, stop);
      if (start >= stop) return res;

      lo  = start;
      hi  = stop - 1;
      top = hi;
      while (lo != hi) begin
        mid = (lo + hi) / 2;
        c = order_of(mid, key, mask);
        if (c < 0) begin
          lo = mid + 1;
        end else begin
          hi = mid;
          if (c > 0) top = hi;
        end
      end
      if (order_of(lo, key, mask) != 0) return res;

      ls = lo;
      while (ls != top) begin
        mid = (ls + top) / 2 + 1;
        c = order_of(mid, key, mask);
        if (c <= 0) ls = mid;
        else top = mid - 1;
      end
      res.first = FIRST_W'(lo);
      res.count = POS_W'(top - lo + 1);
      return res;
    endfunction

    // Called for every accepted input transfer
    function void note_input(logic [CMD_W-1:0] cmd, logic [BKT_W-1:0] addr,
                             logic [KEY_W-1:0] val, logic [KEY_W-1:0] key,
                             logic [LEN_W-1:0] len);
      case (cmd)
        CMD_LOAD_READ: begin
          if (addr < MAX_READS) begin
            prefix_mem[addr] = val;
            prefix_set[addr] = 1'b1;
          end
        end
        CMD_LOAD_BKT: begin
          bucket_mem[addr] = val[POS_W-1:0];
          bucket_set[addr] = 1'b1;
        end
        CMD_LOOKUP: pending_ranges.push_back(search_range(key, len));
        default: ;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    // Called for every accepted output transfer
    function void check_result(logic [FIRST_W-1:0] first, logic [POS_W-1:0] count);
      range_t want;
      answered++;
      if (pending_ranges.size() == 0) begin
        report($sformatf("result %0d (first %0d, count %0d) with no lookup pending",
                         answered, first, count));
        return;
      end
      want = pending_ranges.pop_front();
      if (first !== want.first)
        report($sformatf("result %0d first_match_res: expected %0d, got %0d",
                         answered, want.first, first));
      if (count !== want.count)
        report($sformatf("result %0d match_count: expected %0d, got %0d",
                         answered, want.count, count));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CMD_W-1:0]   command_i;
  logic [BKT_W-1:0]   address_i;
  logic [KEY_W-1:0]   load_value_i;
  logic [KEY_W-1:0]   lookup_key_i;
  logic [LEN_W-1:0]   key_length_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [FIRST_W-1:0] first_match_res_o;
  logic [POS_W-1:0]   match_count_o;
  logic               cfg_we_i;
  logic [POS_W-1:0]   cfg_wdata_i;

  equal_range_tracker ranges = new();

  bit          no_gaps = 1'b0;     // neither side adds random idle cycles
  int unsigned useful_items = 0;   // transfers that change state or give a result
  int unsigned cycle_count = 0;
  int unsigned live_buckets [$];   // buckets of the current read set
  int unsigned live_lo, live_hi;   // read slots of the current read set

  packed_kmer_equal_range_search_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .address_i         (address_i),
    .load_value_i      (load_value_i),
    .lookup_key_i      (lookup_key_i),
    .key_length_i      (key_length_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .first_match_res_o (first_match_res_o),
    .match_count_o     (match_count_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Output side backpressure
  always @(posedge clk_i) begin
    out_stall_i <= !no_gaps && ($urandom_range(99) < 30);
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      ranges.check_result(first_match_res_o, match_count_o);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("packed_kmer_equal_range_search_core_test: errors");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Key lengths weighted toward the edges: zero, short, saturating, full
  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return LEN_W'($urandom_range(1, 7));
    if (r < 26) return LEN_W'($urandom_range(33, 63));
    if (r < 36) return LEN_W'(MAX_BASES);
    return LEN_W'($urandom_range(8, 32));
  endfunction

  // One input transfer; returns at the edge where it was taken
  task automatic send(logic [CMD_W-1:0] cmd, logic [BKT_W-1:0] addr,
                      logic [KEY_W-1:0] val, logic [KEY_W-1:0] key,
                      logic [LEN_W-1:0] len);
    while (!no_gaps && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    address_i    <= addr;
    load_value_i <= val;
    lookup_key_i <= key;
    key_length_i <= len;
    do @(posedge clk_i); while (in_stall_o);
    ranges.note_input(cmd, addr, val, key, len);
    if (cmd == CMD_LOOKUP || cmd == CMD_LOAD_BKT ||
        (cmd == CMD_LOAD_READ && addr < MAX_READS))
      useful_items++;
  endtask

  task automatic load_read(int unsigned slot, logic [KEY_W-1:0] v);
    send(CMD_LOAD_READ, BKT_W'(slot), v, rand64(), LEN_W'($urandom));
  endtask

  task automatic load_bucket(int unsigned code, int unsigned start);
    send(CMD_LOAD_BKT, BKT_W'(code), {rand64() >> POS_W, POS_W'(start)}, rand64(),
         LEN_W'($urandom));
  endtask

  task automatic look(logic [KEY_W-1:0] key, logic [LEN_W-1:0] len);
    send(CMD_LOOKUP, BKT_W'($urandom), rand64(), key, len);
  endtask

  // Hold off input until every answer is in, then let the core go quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ranges.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(int unsigned v);
    cfg_wdata_i <= POS_W'(v);
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ranges.set_read_count(POS_W'(v));
  endtask

  // Lookup mostly near stored reads; falls back to an ignored command if no safe key turns up
  task automatic random_lookup();
    logic [KEY_W-1:0] key, orig;
    logic [LEN_W-1:0] len;
    int unsigned r, tries, sh;
    bit ok;
    ok = 1'b0;
    for (tries = 0; tries < 8 && !ok; tries++) begin
      r   = $urandom_range(99);
      len = pick_len();
      key = rand64();
      if (r < 55 && live_hi > live_lo) begin
        orig = ranges.prefix_mem[$urandom_range(live_lo, live_hi - 1)];
        sh   = 2 * ((len > MAX_BASES) ? MAX_BASES : len);
        key  = orig ^ (rand64() >> sh);
        if ($urandom_range(4) == 0) key ^= 64'h1 << $urandom_range(63);
        key[63:48] = orig[63:48];
      end else if (r < 85 && live_buckets.size() > 0) begin
        key[63:48] = BKT_W'(live_buckets[$urandom_range(live_buckets.size() - 1)]);
      end
      ok = ranges.lookup_safe(key);
    end
    if (ok) look(key, len);
    else send(CMD_UNUSED, BKT_W'($urandom), rand64(), rand64(), pick_len());
  endtask

  // Mix of lookups, rewrites (which break sorting or buckets) and ignored items
  task automatic random_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 72) begin
      random_lookup();
    end else if (r < 80) begin
      if (live_hi > live_lo && $urandom_range(1))
        load_read($urandom_range(live_lo, live_hi - 1), rand64());
      else
        load_read($urandom_range(MAX_READS - 1), rand64());
    end else if (r < 87) begin
      load_bucket($urandom_range(65535), $urandom);
    end else if (r < 93) begin
      send(CMD_LOAD_READ, BKT_W'($urandom_range(MAX_READS, 65535)), rand64(), rand64(),
           pick_len());
    end else begin
      send(CMD_UNUSED, BKT_W'($urandom), rand64(), rand64(), pick_len());
    end
  endtask

  // A fresh sorted read set spread over a few nearby buckets
  task automatic build_set(int unsigned nbkt, int unsigned max_per);
    int unsigned plan_codes [$];
    int unsigned plan_counts [$];
    int unsigned code, total, base, rc, pos, k, j, r;
    logic [47:0] low;
    bit has_last;
    total    = 0;
    has_last = ($urandom_range(3) == 0);
    code     = has_last ? 16'hFFFF - 2 * (nbkt - 1) : $urandom_range(65535 - 2 * nbkt);
    for (k = 0; k < nbkt; k++) begin
      if (k > 0) code += $urandom_range(1, 2);
      if (has_last && k == nbkt - 1) code = 16'hFFFF;
      plan_codes.push_back(code);
      plan_counts.push_back($urandom_range(max_per));
      total += plan_counts[k];
    end
    base = $urandom_range(MAX_READS - total);

    // read_count: exact, cut short, or past the set (only when no last bucket)
    r = $urandom_range(99);
    if (has_last || r < 50) rc = base + total;
    else if (r < 62) rc = $urandom_range(base + total);
    else if (r < 72) rc = 32767;
    else if (r < 78) rc = 0;
    else rc = $urandom_range(base + total, 32767);
    drain();
    write_cfg(rc);

    live_buckets = plan_codes;
    live_lo      = base;
    live_hi      = base + total;
    pos          = base;
    for (k = 0; k < nbkt; k++) begin
      load_bucket(plan_codes[k], pos);
      low = 48'(rand64() >> $urandom_range(16, 63));
      for (j = 0; j < plan_counts[k]; j++) begin
        load_read(pos, {BKT_W'(plan_codes[k]), low});
        pos++;
        // duplicates, neighbors and jumps at every base position
        case ($urandom_range(3))
          0: ;
          1: low += 48'd1;
          2: low += 48'(64'($urandom) << $urandom_range(16));
          default: low += 48'(64'h1 << $urandom_range(45));
        endcase
      end
      if (plan_codes[k] != LAST_BUCKET &&
          (k == nbkt - 1 || plan_codes[k + 1] != plan_codes[k] + 1))
        load_bucket(plan_codes[k] + 1, pos);
    end
  endtask

  initial begin
    int unsigned i, phase, ops;
    in_valid_i   = 1'b0;
    command_i    = CMD_LOAD_READ;
    address_i    = '0;
    load_value_i = '0;
    lookup_key_i = '0;
    key_length_i = '0;
    out_stall_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: small bucket with duplicates, last bucket, ignored items
    send(CMD_LOAD_BKT, 16'h1234, {49'h1_FFFF_FFFF_FFFF, 15'd0}, 64'hFFFF_FFFF_FFFF_FFFF,
         6'h3F);
    load_bucket(16'h1235, 3);
    load_read(0, 64'h1234_0000_0000_0000);
    load_read(1, 64'h1234_0000_0000_0000);
    load_read(2, 64'h1234_FFFF_FFFF_FFFF);
    load_read(3, 64'hFFFF_0000_0000_0001);
    load_read(4, 64'hFFFF_FFFF_FFFF_FFFF);
    load_bucket(16'hFFFF, 3);
    send(CMD_LOAD_READ, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    send(CMD_LOAD_READ, 16'h4000, '0, '0, '0);
    // read_count still zero: every bucket is empty
    look(64'h1234_0000_0000_0000, 6'd32);
    send(CMD_UNUSED, 16'hFFFF, '0, 64'h1234_0000_0000_0000, 6'd32);
    drain();
    write_cfg(5);
    look(64'h1234_0000_0000_0000, 6'd32);
    look(64'h1234_0000_0000_0000, 6'd63);
    look(64'h1234_0000_0000_0000, 6'd0);
    look(64'h1234_5555_0000_0000, 6'd4);
    look(64'h1234_0000_0000_0000, 6'd8);
    look(64'h1234_FFFF_FFFF_FFFF, 6'd32);
    look(64'h1234_8000_0000_0000, 6'd32);
    look(64'hFFFF_0000_0000_0001, 6'd32);
    look(64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
    // reversed bucket
    load_bucket(16'h0000, 7);
    load_bucket(16'h0001, 2);
    look(64'h0000_0000_0000_0000, 6'd32);

    // Top of the table in one bucket whose end lies past the table;
    // read_count above the table, then at its size
    drain();
    write_cfg(32767);
    for (i = MAX_READS - 64; i < MAX_READS; i++)
      load_read(i, (i == MAX_READS - 1) ? 64'h0000_FFFF_FFFF_FFFF :
                   {16'h0000, 18'(i >> 1), 30'($urandom)});
    load_bucket(16'h0000, MAX_READS - 64);
    load_bucket(16'h0001, 20000);
    load_bucket(16'hFFFF, MAX_READS - 4);
    look(64'h0, 6'd0);
    look(64'h0000_FFFF_FFFF_FFFF, 6'd32);
    look(64'hFFFF_0000_0000_0000, 6'd0);
    live_buckets = '{0, 16'hFFFF};
    live_lo      = MAX_READS - 64;
    live_hi      = MAX_READS;
    repeat (20) random_lookup();
    drain();
    write_cfg(MAX_READS);
    look(64'h0, 6'd0);
    look(64'h0000_FFFF_FFFF_FFFF, 6'd63);
    repeat (10) random_lookup();

    // Random phases, each with its own read set and read_count
    phase = 0;
    while (useful_items < ITEMS) begin
      no_gaps = (phase == 1);
      build_set($urandom_range(1, 4), ($urandom_range(4) == 0) ? 64 : 12);
      ops = no_gaps ? 150 : $urandom_range(20, 60);
      repeat (ops) random_op();
      phase++;
    end
    no_gaps = 1'b0;

    drain();
    if (ranges.errors == 0 && ranges.pending() == 0)
      $display("packed_kmer_equal_range_search_core_test: clean");
    else
      $display("packed_kmer_equal_range_search_core_test: errors");
    $finish;
  end

endmodule
